// ===== design/spf_pkg.sv =====
`default_nettype none
package spf_pkg;

  // coordinate format
  localparam int CW = 32;             // coordinate width
  localparam int FB = 16;             // fraction bits

  // derived widths
  localparam int DW   = CW + 1;       // coordinate difference
  localparam int PW   = 2 * DW;       // product of two differences
  localparam int SW   = PW + 2;       // sum of three products
  localparam int NW   = SW + FB + 2;  // scaled dividend
  localparam int DVW  = SW + 1;       // doubled divisor
  localparam int NST  = CW + 3;       // quotient bits, one divider stage each
  localparam int CMPW = DVW + NST;    // divider compare width
  localparam int GW   = NST;          // internal gamma, signed
  localparam int PGW  = GW + DW;      // gamma times difference
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [NST-1:0] GAMMA_LIM = NST'(1) << (CW + 1);
  localparam logic [GW-1:0]  GAMMA_HALF = GW'(1) << (FB - 1);
  localparam logic [PGW-1:0] ROUND_HALF = PGW'(1) << (FB - 1);

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [2:0][CW-1:0] vec_t;
  typedef logic [2:0][DW-1:0] dvec_t;

  // one classified request between front and back
  typedef struct packed {
    logic [SW-1:0] num;
    logic [SW-1:0] den;
    vec_t          c;
    vec_t          k;
    dvec_t         u;
  } q_ent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // per-request data that rides along the divider
  typedef struct packed {
    logic  deg;
    logic  neg;
    vec_t  c;
    vec_t  k;
    dvec_t u;
  } side_t;

  // clamp a gamma-width value to the coordinate range
  function automatic coord_t sat_g(input logic [GW-1:0] v);
    logic [GW-CW:0] top;
    top = v[GW-1:CW-1];
    if ((&top) || !(|top)) return v[CW-1:0];
    return v[GW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  endfunction

  // clamp a product-width value to the coordinate range
  function automatic coord_t sat_p(input logic [PGW-1:0] v);
    logic [PGW-CW:0] top;
    top = v[PGW-1:CW-1];
    if ((&top) || !(|top)) return v[CW-1:0];
    return v[PGW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  endfunction

  // clamp a one-bit-wider value to the coordinate range
  function automatic coord_t sat_d(input logic [DW-1:0] v);
    if (v[DW-1] == v[DW-2]) return v[CW-1:0];
    return v[DW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  endfunction

endpackage
`default_nettype wire

// ===== design/spf_if.sv =====
`default_nettype none
interface spf_in_if;
  logic valid;
  logic ready;
  logic signed [spf_pkg::CW-1:0] patch_x, patch_y, patch_z;
  logic signed [spf_pkg::CW-1:0] joint_x, joint_y, joint_z;
  logic signed [spf_pkg::CW-1:0] child_x, child_y, child_z;
  modport source (output valid, patch_x, patch_y, patch_z, joint_x, joint_y, joint_z,
                  child_x, child_y, child_z, input ready);
  modport sink (input valid, patch_x, patch_y, patch_z, joint_x, joint_y, joint_z,
                child_x, child_y, child_z, output ready);
endinterface

interface spf_out_if;
  logic valid;
  logic ready;
  logic signed [spf_pkg::CW-1:0] gamma;
  logic signed [spf_pkg::CW-1:0] foot_x, foot_y, foot_z;
  logic signed [spf_pkg::CW-1:0] offset_x, offset_y, offset_z;
  logic degenerate;
  modport source (output valid, gamma, foot_x, foot_y, foot_z, offset_x, offset_y, offset_z,
                  degenerate, input ready);
  modport sink (input valid, gamma, foot_x, foot_y, foot_z, offset_x, offset_y, offset_z,
                degenerate, output ready);
endinterface
`default_nettype wire

// ===== design/segment_projection_foot_unit.sv =====
// Segment projection foot unit.
// A request on in_chan carries a patch centre and the two end joints of a
// bone as signed Q16.16 points. Each request yields one result on out_chan:
// the line parameter gamma (1 at the joint, 0 at the child), the
// perpendicular foot on the line, the foot minus the centre, and a flag
// that marks coinciding joints (gamma then reads 0.5, the foot the joint).
// All outputs saturate to the 32-bit signed range.
// Both channels use valid/ready; a transfer happens when both are high.
// Throughput: one request per cycle, sustained while out_chan.ready is high.
// On its way to out_chan a request passes through 2 front stages
// (differences, products), the queue write, 1 setup stage, 35 divider
// stages (one quotient bit each), the product and foot stages, and the
// offset stage, which is the output register.
// A 4-entry queue sits between the front and the back; when out_chan.ready
// is low the back pipeline holds, the queue fills, and then in_chan.ready
// drops. Reset empties the pipeline and queue; nothing else needs clearing.
`default_nettype none
module segment_projection_foot_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  spf_in_if.sink    in_chan,
  spf_out_if.source out_chan
);

  spf_pkg::q_stat_t q_stat;
  spf_pkg::q_ent_t  q_wdata, q_rdata;
  logic q_push, q_pop;

  spf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_stat  (q_stat),
    .q_pop   (q_pop),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  spf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .stat      (q_stat)
  );

  spf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule
`default_nettype wire

// ===== design/spf_front.sv =====
`default_nettype none
module spf_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  spf_in_if.sink                 in_chan,
  input  wire spf_pkg::q_stat_t  q_stat,
  input  wire logic              q_pop,
  output logic                   q_push,
  output spf_pkg::q_ent_t        q_data
);

  logic fadv;
  logic va_r, vb_r;
  spf_pkg::vec_t  ca_r, ka_r, cb_r, kb_r;
  spf_pkg::dvec_t ua_r, va_d_r, ub_r;
  logic [2:0][spf_pkg::PW-1:0] pvu_r, puu_r;
  spf_pkg::vec_t  cin, jin, kin;

  // hold the front while the queue has no room for the request in stage B
  assign fadv = !vb_r || !q_stat.full || q_pop;
  assign in_chan.ready = fadv;
  assign q_push = vb_r && fadv;

  assign cin = {in_chan.patch_z, in_chan.patch_y, in_chan.patch_x};
  assign jin = {in_chan.joint_z, in_chan.joint_y, in_chan.joint_x};
  assign kin = {in_chan.child_z, in_chan.child_y, in_chan.child_x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (fadv) begin
      va_r <= in_chan.valid;
      vb_r <= va_r;
    end
  end

  // stage A: differences; stage B: products
  always_ff @(posedge clk) begin
    if (fadv) begin
      for (int i = 0; i < 3; i++) begin
        ua_r[i]   <= {jin[i][spf_pkg::CW-1], jin[i]} - {kin[i][spf_pkg::CW-1], kin[i]};
        va_d_r[i] <= {cin[i][spf_pkg::CW-1], cin[i]} - {kin[i][spf_pkg::CW-1], kin[i]};
        pvu_r[i]  <= $signed(va_d_r[i]) * $signed(ua_r[i]);
        puu_r[i]  <= $signed(ua_r[i]) * $signed(ua_r[i]);
      end
      ca_r <= cin;
      ka_r <= kin;
      cb_r <= ca_r;
      kb_r <= ka_r;
      ub_r <= ua_r;
    end
  end

  // sum the dot products into the queue entry
  always_comb begin
    q_data.num = {{2{pvu_r[0][spf_pkg::PW-1]}}, pvu_r[0]}
               + {{2{pvu_r[1][spf_pkg::PW-1]}}, pvu_r[1]}
               + {{2{pvu_r[2][spf_pkg::PW-1]}}, pvu_r[2]};
    q_data.den = {{2{puu_r[0][spf_pkg::PW-1]}}, puu_r[0]}
               + {{2{puu_r[1][spf_pkg::PW-1]}}, puu_r[1]}
               + {{2{puu_r[2][spf_pkg::PW-1]}}, puu_r[2]};
    q_data.c = cb_r;
    q_data.k = kb_r;
    q_data.u = ub_r;
  end

endmodule
`default_nettype wire

// ===== design/spf_queue.sv =====
`default_nettype none
module spf_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire spf_pkg::q_ent_t  push_data,
  input  wire logic             pop,
  output spf_pkg::q_ent_t       pop_data,
  output spf_pkg::q_stat_t      stat
);

  spf_pkg::q_ent_t mem_r [spf_pkg::QDEPTH];
  logic [spf_pkg::QAW-1:0] wp_r, rp_r;
  logic [spf_pkg::QAW:0]   cnt_r;

  assign stat.full  = (cnt_r == (spf_pkg::QAW+1)'(spf_pkg::QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_data   = mem_r[rp_r];

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

endmodule
`default_nettype wire

// ===== design/spf_back.sv =====
`default_nettype none
module spf_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire spf_pkg::q_stat_t  q_stat,
  input  wire spf_pkg::q_ent_t   q_data,
  output logic                   q_pop,
  spf_out_if.source              out_chan
);

  localparam int NST = spf_pkg::NST;
  localparam int CW  = spf_pkg::CW;

  logic adv;
  logic [NST:0] v_r;
  logic [spf_pkg::NW-1:0]  rem_r [NST+1];
  logic [NST-1:0]          q_r   [NST+1];
  logic [spf_pkg::DVW-1:0] d_r   [NST+1];
  spf_pkg::side_t          sd_r  [NST+1];

  logic vg_r, vf_r, vo_r;
  logic [2:0][spf_pkg::PGW-1:0] pg_r;
  spf_pkg::vec_t  cg_r, kg_r, cf_r, foot_f_r;
  spf_pkg::coord_t gam_g_r, gam_f_r;
  logic deg_g_r, deg_f_r;

  spf_pkg::coord_t gam_o_r;
  spf_pkg::vec_t   foot_o_r, off_o_r;
  logic            deg_o_r;

  // the whole back pipeline moves when the output register can take a result
  assign adv   = !vo_r || out_chan.ready;
  assign q_pop = adv && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      vg_r <= 1'b0;
      vf_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (adv) begin
      v_r  <= {v_r[NST-1:0], q_pop};
      vg_r <= v_r[NST];
      vf_r <= vg_r;
      vo_r <= vf_r;
    end
  end

  // prepare dividend and divisor: (2|num|*2^FB + den) / (2 den)
  logic neg_in;
  logic [spf_pkg::SW-1:0] mag_in;
  assign neg_in = q_data.num[spf_pkg::SW-1];
  assign mag_in = neg_in ? -q_data.num : q_data.num;

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= {mag_in, {(spf_pkg::FB+1){1'b0}}}
                + {{(spf_pkg::FB+2){1'b0}}, q_data.den};
      d_r[0]   <= {q_data.den, 1'b0};
      q_r[0]   <= '0;
      sd_r[0].deg <= (q_data.den == '0);
      sd_r[0].neg <= neg_in;
      sd_r[0].c   <= q_data.c;
      sd_r[0].k   <= q_data.k;
      sd_r[0].u   <= q_data.u;
    end
  end

  // restoring divider, one quotient bit per stage, top bit flags overflow
  for (genvar s = 0; s < NST; s++) begin : g_div
    localparam int B = NST - 1 - s;
    logic [spf_pkg::CMPW-1:0] r_ext, d_sh;
    logic ge;
    assign r_ext = spf_pkg::CMPW'(rem_r[s]);
    assign d_sh  = spf_pkg::CMPW'(d_r[s]) << B;
    assign ge    = (r_ext >= d_sh);
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s+1] <= ge ? spf_pkg::NW'(r_ext - d_sh) : rem_r[s];
        q_r[s+1]   <= q_r[s] | (NST'(ge) << B);
        d_r[s+1]   <= d_r[s];
        sd_r[s+1]  <= sd_r[s];
      end
    end
  end

  // clamp the quotient, apply sign, form gamma*(j-k)
  logic [NST-1:0] qc;
  logic signed [spf_pkg::GW-1:0] gc;
  spf_pkg::side_t sd_e;
  assign sd_e = sd_r[NST];
  assign qc   = (q_r[NST] > spf_pkg::GAMMA_LIM) ? spf_pkg::GAMMA_LIM : q_r[NST];
  always_comb begin
    if (sd_e.deg)      gc = spf_pkg::GAMMA_HALF;
    else if (sd_e.neg) gc = -$signed(qc);
    else               gc = $signed(qc);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pg_r[i] <= gc * $signed(sd_e.u[i]);
      end
      gam_g_r <= spf_pkg::sat_g(gc);
      deg_g_r <= sd_e.deg;
      cg_r    <= sd_e.c;
      kg_r    <= sd_e.k;
    end
  end

  // round, add the child joint, saturate the foot
  logic [2:0][spf_pkg::PGW-1:0] ft;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ft[i] = ($signed(pg_r[i] + spf_pkg::ROUND_HALF) >>> spf_pkg::FB)
            + $signed({{(spf_pkg::PGW-CW){kg_r[i][CW-1]}}, kg_r[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        foot_f_r[i] <= spf_pkg::sat_p(ft[i]);
      end
      gam_f_r <= gam_g_r;
      deg_f_r <= deg_g_r;
      cf_r    <= cg_r;
    end
  end

  // offset from the saturated foot, into the output register
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        off_o_r[i] <= spf_pkg::sat_d({foot_f_r[i][CW-1], foot_f_r[i]}
                                     - {cf_r[i][CW-1], cf_r[i]});
      end
      foot_o_r <= foot_f_r;
      gam_o_r  <= gam_f_r;
      deg_o_r  <= deg_f_r;
    end
  end

  assign out_chan.valid      = vo_r;
  assign out_chan.gamma      = gam_o_r;
  assign out_chan.foot_x     = foot_o_r[0];
  assign out_chan.foot_y     = foot_o_r[1];
  assign out_chan.foot_z     = foot_o_r[2];
  assign out_chan.offset_x   = off_o_r[0];
  assign out_chan.offset_y   = off_o_r[1];
  assign out_chan.offset_z   = off_o_r[2];
  assign out_chan.degenerate = deg_o_r;

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = spf_pkg::CW;
  localparam int FB = spf_pkg::FB;
  localparam int HOLD_LEN = 200;

  typedef spf_pkg::coord_t coord_t;
  typedef logic signed [159:0] wint_t;

  // one request: patch, joint, child coordinates plus driver hints
  typedef struct packed {
    logic                drain;  // wait for all results before offering
    logic                calm;   // no idle bursts around this request
    logic [8:0][CW-1:0]  f;
  } req_t;

  // one result: gamma, foot xyz, offset xyz, degenerate flag
  typedef struct packed {
    logic [6:0][CW-1:0] r;
    logic               deg;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  spf_in_if  req_bus();
  spf_out_if res_bus();

  segment_projection_foot_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_bus),
    .out_chan (res_bus)
  );

  always #4 clk = ~clk;

  req_t pending_reqs[$];
  res_t expected_results[$];
  int   accepted_cnt = 0;
  int   offered_cnt = 0;
  int   result_cnt = 0;
  int   mismatch_cnt = 0;
  int   degen_cnt = 0;
  int   sat_cnt = 0;
  int   total_reqs = 0;
  bit   done_filling = 1'b0;
  int   src_gap = 0;
  req_t cur_req;

  function automatic wint_t widen(input coord_t x);
    return x;
  endfunction

  function automatic coord_t clamp(input wint_t x);
    wint_t hi, lo;
    hi = (wint_t'(1) <<< (CW - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return hi[CW-1:0];
    if (x < lo) return lo[CW-1:0];
    return x[CW-1:0];
  endfunction

  // compute gamma, foot and offset for one request
  function automatic res_t project_foot(input req_t q);
    wint_t c[3], k[3], u[3], num, den, mag, quo, gc, p;
    coord_t foot;
    res_t res;
    num = 0;
    den = 0;
    for (int i = 0; i < 3; i++) begin
      c[i] = widen(q.f[i]);
      k[i] = widen(q.f[6+i]);
      u[i] = widen(q.f[3+i]) - k[i];
      num += (c[i] - k[i]) * u[i];
      den += u[i] * u[i];
    end
    res.deg = (den == 0);
    if (res.deg) begin
      gc = wint_t'(1) <<< (FB - 1);
    end else begin
      mag = (num < 0) ? -num : num;
      quo = ((mag <<< (FB + 1)) + den) / (den <<< 1);
      if (quo > (wint_t'(1) <<< (CW + 1))) quo = wint_t'(1) <<< (CW + 1);
      gc = (num < 0) ? -quo : quo;
    end
    res.r[0] = clamp(gc);
    for (int i = 0; i < 3; i++) begin
      p = (gc * u[i] + (wint_t'(1) <<< (FB - 1))) >>> FB;
      foot = clamp(p + k[i]);
      res.r[1+i] = foot;
      res.r[4+i] = clamp(widen(foot) - c[i]);
    end
    return res;
  endfunction

  function automatic coord_t rnd_coord();
    case ($urandom_range(0, 6))
      0:       return {1'b0, {(CW-1){1'b1}}};
      1:       return {1'b1, {(CW-1){1'b0}}};
      2, 3:    return $urandom;
      default: return $signed($urandom_range(0, 40 << FB)) - (20 << FB);
    endcase
  endfunction

  function automatic req_t mk_req(input coord_t px, py, pz, jx, jy, jz, kx, ky, kz);
    req_t q;
    q.drain = 1'b0;
    q.calm  = 1'b0;
    q.f = {kz, ky, kx, jz, jy, jx, pz, py, px};
    return q;
  endfunction

  // well-formed geometry: centre near the segment, sometimes degenerate
  function automatic req_t rnd_req();
    coord_t j[3], k[3], c[3];
    int t;
    req_t q;
    t = int'($urandom_range(0, 7 << FB)) - (3 << FB);
    for (int i = 0; i < 3; i++) begin
      j[i] = rnd_coord();
      k[i] = ($urandom_range(0, 9) == 0) ? j[i] : rnd_coord();
      case ($urandom_range(0, 3))
        0:       c[i] = rnd_coord();
        default: c[i] = k[i] + ((longint'(t) * (longint'(j[i]) - longint'(k[i]))) >>> FB)
                        + $signed($urandom_range(0, 2000)) - 1000;
      endcase
    end
    q = mk_req(c[0], c[1], c[2], j[0], j[1], j[2], k[0], k[1], k[2]);
    return q;
  endfunction

  // offer requests at the falling edge, holding each until accepted
  always @(negedge clk) begin
    automatic int gap_left;
    automatic bit pick;
    if (!rst_n) begin
      req_bus.valid <= 1'b0;
      req_bus.patch_x <= '0; req_bus.patch_y <= '0; req_bus.patch_z <= '0;
      req_bus.joint_x <= '0; req_bus.joint_y <= '0; req_bus.joint_z <= '0;
      req_bus.child_x <= '0; req_bus.child_y <= '0; req_bus.child_z <= '0;
    end else if (!req_bus.valid || accepted_cnt == offered_cnt) begin
      pick = 1'b0;
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
      end else if (pending_reqs.size() > 0) begin
        if (pending_reqs[0].drain && expected_results.size() != 0) begin
          pick = 1'b0;
        end else if (!pending_reqs[0].calm && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(1, 5);
          src_gap <= gap_left - 1;
        end else begin
          pick = 1'b1;
        end
      end
      if (pick) begin
        cur_req = pending_reqs.pop_front();
        req_bus.patch_x <= cur_req.f[0]; req_bus.patch_y <= cur_req.f[1];
        req_bus.patch_z <= cur_req.f[2]; req_bus.joint_x <= cur_req.f[3];
        req_bus.joint_y <= cur_req.f[4]; req_bus.joint_z <= cur_req.f[5];
        req_bus.child_x <= cur_req.f[6]; req_bus.child_y <= cur_req.f[7];
        req_bus.child_z <= cur_req.f[8];
        offered_cnt <= offered_cnt + 1;
      end
      req_bus.valid <= pick;
    end
  end

  // record accepted requests and their predicted results
  always @(posedge clk) begin
    automatic req_t q;
    if (rst_n && req_bus.valid && req_bus.ready) begin
      q = mk_req(req_bus.patch_x, req_bus.patch_y, req_bus.patch_z,
                 req_bus.joint_x, req_bus.joint_y, req_bus.joint_z,
                 req_bus.child_x, req_bus.child_y, req_bus.child_z);
      expected_results.push_back(project_foot(q));
      accepted_cnt <= accepted_cnt + 1;
    end
  end

  // receiver: random stalls, one long hold once traffic is flowing
  int  hold_left = 0;
  bit  held_once = 1'b0;
  int  sink_gap = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      res_bus.ready <= 1'b0;
    end else if (!held_once && accepted_cnt >= 300) begin
      held_once <= 1'b1;
      hold_left <= HOLD_LEN;
      res_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_bus.ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      res_bus.ready <= 1'b0;
    end else if (!(done_filling && accepted_cnt >= total_reqs - 150)
                 && $urandom_range(0, 5) == 0) begin
      sink_gap <= $urandom_range(0, 4);
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= 1'b1;
    end
  end

  // compare each delivered result with the oldest prediction
  always @(posedge clk) begin
    automatic res_t got, want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      got.r = {res_bus.offset_z, res_bus.offset_y, res_bus.offset_x,
               res_bus.foot_z, res_bus.foot_y, res_bus.foot_x, res_bus.gamma};
      got.deg = res_bus.degenerate;
      result_cnt <= result_cnt + 1;
      if (expected_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_results.pop_front();
        if (want.deg) degen_cnt++;
        if (want.r[0] == {1'b0, {(CW-1){1'b1}}} || want.r[0] == {1'b1, {(CW-1){1'b0}}})
          sat_cnt++;
        if (got != want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch at result %0d:", result_cnt);
            $display("  gamma exp %h got %h  deg exp %b got %b",
                     want.r[0], got.r[0], want.deg, got.deg);
            $display("  foot exp %h %h %h got %h %h %h",
                     want.r[1], want.r[2], want.r[3], got.r[1], got.r[2], got.r[3]);
            $display("  offs exp %h %h %h got %h %h %h",
                     want.r[4], want.r[5], want.r[6], got.r[4], got.r[5], got.r[6]);
          end
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    automatic coord_t mx = {1'b0, {(CW-1){1'b1}}};
    automatic coord_t mn = {1'b1, {(CW-1){1'b0}}};
    automatic coord_t one = 1 << FB;
    automatic req_t q;
    // coinciding joints, including extremes
    pending_reqs.push_back(mk_req(0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(mx, mn, mx, mn, mx, mn, mn, mx, mn));
    pending_reqs.push_back(mk_req(mn, mn, mn, mx, mx, mx, mx, mx, mx));
    // centre on joint, on child, projecting onto the midpoint
    pending_reqs.push_back(mk_req(one, 0, 0, one, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(0, 0, 0, one, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(one / 2, 5 * one, -3 * one, one, 0, 0, 0, 0, 0));
    // longest segment, extreme centres
    pending_reqs.push_back(mk_req(mx, mx, mx, mx, mx, mx, mn, mn, mn));
    pending_reqs.push_back(mk_req(mn, mx, mn, mn, mn, mn, mx, mx, mx));
    pending_reqs.push_back(mk_req(0, 0, 0, mx, mn, mx, mn, mx, mn));
    // tiny segment, far centre: gamma saturates both ways
    pending_reqs.push_back(mk_req(mx, mx, mx, 1, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(mn, mn, mn, 1, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(mx, 0, 0, 0, 0, 0, 1, 1, 1));
    // rounding ties of gamma and of the foot products
    pending_reqs.push_back(mk_req(1, 0, 0, 3, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(-1, 0, 0, 3, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(-1, 7, 0, 3, 1, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(0, 0, 0, 1, -1, 1, -1, 1, -1));
    pending_reqs.push_back(mk_req(-1, -1, -1, -1, -1, -1, 0, 0, 0));
    // random well-formed geometry with occasional drain pauses
    for (int n = 0; n < 900; n++) begin
      q = rnd_req();
      q.drain = (n == 150 || n == 600);
      q.calm  = (n >= 750);
      pending_reqs.push_back(q);
    end
    total_reqs = pending_reqs.size();
    done_filling = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_reqs.size() == 0 && accepted_cnt == offered_cnt
          && accepted_cnt == total_reqs);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Checked %0d results from %0d requests: %0d degenerate, %0d saturated gamma.",
             result_cnt, accepted_cnt, degen_cnt, sat_cnt);
    $display("Covered extremes, rounding ties, a long receiver hold and two drain pauses.");
    if (mismatch_cnt == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("FAIL");
    end
    $finish;
  end

  // hard time limit
  initial begin
    #(8ns * 200000);
    $display("timeout");
    $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire
